// ----- hdl/clc_pkg.sv -----
// Shared types for the circular list engine: operation codes, status codes, cell control.
package clc_pkg;

  typedef enum logic [2:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_REM_HEAD = 3'd2,
    MODE_REM_TAIL = 3'd3,
    MODE_DELETE   = 3'd4,
    MODE_SEARCH   = 3'd5
  } clc_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } clc_status_e;

  // Broadcast control for the row of cells, one command per cycle.
  typedef struct packed {
    logic capture;   // latch the key compare result
    logic ins_head;  // every cell takes its head-side neighbor
    logic ins_tail;  // the cell at the tail slot takes the new value
    logic rem_head;  // every cell takes its tail-side neighbor
    logic del;       // cells at or past the first match take their tail-side neighbor
  } clc_ctl_t;

endpackage

// ----- hdl/clc_cell.sv -----
// One storage cell of the list row: a value, its key compare flag and the shift mux.
module clc_cell import clc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  clc_ctl_t               ctl_i,
  input  logic                   at_tail_i,
  input  logic                   shift_i,
  input  logic [VALUE_WIDTH-1:0] cmp_i,
  input  logic [VALUE_WIDTH-1:0] new_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] value_q;
  logic                   match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      match_q <= (value_q == cmp_i);
    end
    if (ctl_i.ins_head) begin
      value_q <= left_i;
    end else if (ctl_i.ins_tail && at_tail_i) begin
      value_q <= new_i;
    end else if (ctl_i.rem_head || (ctl_i.del && shift_i)) begin
      value_q <= right_i;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- hdl/circular_list_engine.sv -----
// Top level of the circular list engine: a row of shifting cells with parallel key compare.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | mode_i, value_i
//   out     | output    | out_valid_o / out_stall_i | out_value_o, found_o, position_o,
//           |           |                           | count_o, status_o
//
// Each item passes an accept cycle and a resolve step: the accept cycle latches the operation and
// lets every cell compare its value against the key; the resolve step, taken once the result
// register is free or being read, resolves the first match, shifts the row and loads the result
// register. A stalled result holds the block in its resolve step, but the next item is taken
// while the result waits as long as no item is in flight.
// Reset clears the element count, the in-flight flag and the result valid; cell
// contents stay as they are and are never read until written.
module circular_list_engine import clc_pkg::*; #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_value_o,
  output logic               found_o,
  output logic [3:0]         position_o,
  output logic [4:0]         count_o,
  output logic [1:0]         status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned W  = VALUE_WIDTH;

  // Control and operation registers.
  logic          busy_q;
  logic [2:0]    mode_q;
  logic [W-1:0]  key_q;
  logic [CW-1:0] count_q, count_d;

  // Result register.
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic        found_q;
  logic [3:0]  position_q;
  logic [4:0]  count_out_q;
  logic [1:0]  status_q;

  logic          accept, exec;
  logic [W+31:0] key_sx;
  logic [W-1:0]  key_in;
  clc_ctl_t      ctl;

  logic [CAPACITY-1:0] cell_match, occ, at_tail, is_last;
  logic [CAPACITY-1:0] hit, first_hit, shift_vec;
  logic [W-1:0]        cell_val [CAPACITY];
  logic [W-1:0]        tail_val;
  logic [PW-1:0]       hit_pos;
  logic                any_hit, full, empty;

  logic [W-1:0]       res_val;
  logic               res_found;
  logic [PW-1:0]      res_pos;
  clc_status_e        res_status;
  logic [W+31:0]      res_val_ext;
  logic [PW+3:0]      pos_ext;
  logic [CW+4:0]      cnt_ext;

  // Handshake: one item in flight; the result is written when the output slot frees up.
  assign accept     = in_valid_i && !busy_q;
  assign exec       = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  // Keep the key at the storage width: sign extend or truncate.
  assign key_sx = {{W{value_i[31]}}, value_i};
  assign key_in = key_sx[W-1:0];

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  // Row of cells; the head cell sees the new value as its head-side neighbor and the
  // last cell sees itself as its tail-side neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(i);
    localparam logic [CW-1:0] NEXT = CW'(i + 1);
    logic [W-1:0] left_v, right_v;

    assign occ[i]     = (IDX < count_q);
    assign at_tail[i] = (count_q == IDX);
    assign is_last[i] = (count_q == NEXT);

    if (i == 0) begin : g_head
      assign left_v = key_q;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end

    clc_cell #(
      .VALUE_WIDTH(W)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .at_tail_i(at_tail[i]),
      .shift_i  (shift_vec[i]),
      .cmp_i    (key_in),
      .new_i    (key_q),
      .left_i   (left_v),
      .right_i  (right_v),
      .value_o  (cell_val[i]),
      .match_o  (cell_match[i])
    );
  end

  // First match from the head: isolate the lowest set bit, then mark it and every
  // cell past it for the delete shift.
  assign hit       = cell_match & occ;
  assign any_hit   = |hit;
  assign first_hit = hit & (~hit + CAPACITY'(1));
  assign shift_vec = ~(first_hit - CAPACITY'(1));

  always_comb begin
    hit_pos  = '0;
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_pos = hit_pos | PW'(i);
      end
      if (is_last[i]) begin
        tail_val = tail_val | cell_val[i];
      end
    end
  end

  // Decode the latched operation into row commands and the result.
  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    count_d     = count_q;
    res_val     = '0;
    res_found   = 1'b0;
    res_pos     = '0;
    res_status  = STATUS_OK;
    case (mode_q)
      MODE_INS_HEAD, MODE_INS_TAIL: begin
        if (full) begin
          res_status = STATUS_FULL;
        end else begin
          ctl.ins_head = exec && (mode_q == MODE_INS_HEAD);
          ctl.ins_tail = exec && (mode_q == MODE_INS_TAIL);
          count_d      = count_q + CW'(1);
        end
      end
      MODE_REM_HEAD: begin
        if (empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          ctl.rem_head = exec;
          res_val      = cell_val[0];
          count_d      = count_q - CW'(1);
        end
      end
      MODE_REM_TAIL: begin
        if (empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_val = tail_val;
          count_d = count_q - CW'(1);
        end
      end
      MODE_DELETE: begin
        ctl.del   = exec;
        res_found = any_hit;
        res_pos   = hit_pos;
        if (any_hit) begin
          count_d = count_q - CW'(1);
        end
      end
      MODE_SEARCH: begin
        res_found = any_hit;
        res_pos   = hit_pos;
      end
      default: begin
      end
    endcase
  end

  assign res_val_ext = {32'b0, res_val};
  assign pos_ext     = {4'b0, res_pos};
  assign cnt_ext     = {5'b0, count_d};

  // Control state: in-flight flag, element count, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= key_in;
    end
    if (exec) begin
      out_value_q <= res_val_ext[31:0];
      found_q     <= res_found;
      position_q  <= pos_ext[3:0];
      count_out_q <= cnt_ext[4:0];
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign found_o     = found_q;
  assign position_o  = position_q;
  assign count_o     = count_out_q;
  assign status_o    = status_q;

endmodule

// ----- hdl/clc_checker.sv -----
// Port-level checks for the circular list engine and their bind.
module clc_checker import clc_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               found_o,
  input logic [3:0]         position_o,
  input logic [4:0]         count_o,
  input logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == STATUS_OK)
    else $error("match reported with an error status");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == 4'd0)
    else $error("position set without a match");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CAPACITY < 32) |-> count_o <= CAPACITY)
    else $error("element count beyond capacity");

endmodule

bind circular_list_engine clc_checker #(
  .CAPACITY(CAPACITY)
) u_clc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .found_o    (found_o),
  .position_o (position_o),
  .count_o    (count_o),
  .status_o   (status_o)
);

// ----- verif/clc_list_checker.sv -----
// Checker for the circular list engine: shadow list, expected-result queue, field compare.
`timescale 1ns / 1ps

module clc_list_checker import clc_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_value_i,
  input  logic               found_i,
  input  logic [3:0]         position_i,
  input  logic [4:0]         count_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 full_hits_o,
  output int                 empty_hits_o,
  output int                 match_hits_o
);

  typedef struct packed {
    logic [31:0] out_value;
    logic        found;
    logic [3:0]  position;
    logic [4:0]  count;
    clc_status_e status;
  } list_result_t;

  logic [31:0]  shadow_cells [CAPACITY];
  int           shadow_fill;
  list_result_t expected_results_q [$];
  int           fail_count = 0;
  int           checked    = 0;
  int           full_hits  = 0;
  int           empty_hits = 0;
  int           match_hits = 0;

  assign fail_count_o = fail_count;
  assign checked_o    = checked;
  assign full_hits_o  = full_hits;
  assign empty_hits_o = empty_hits;
  assign match_hits_o = match_hits;

  // Close the gap left at cell idx by pulling every later cell one step toward the head.
  function automatic void close_gap(input int idx);
    int i;
    for (i = idx; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i + 1];
    shadow_fill--;
  endfunction

  // Apply one operation to the shadow list and return the result it should produce.
  function automatic list_result_t apply_list_op(input logic [2:0] mode, input logic [31:0] key);
    list_result_t res;
    int           hit;
    int           i;
    res        = '0;
    res.status = STATUS_OK;
    hit        = -1;
    for (i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_cells[i] == key) hit = i;
    end
    case (clc_mode_e'(mode))
      MODE_INS_HEAD: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          for (i = shadow_fill; i > 0; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[0] = key;
          shadow_fill++;
        end
      end
      MODE_INS_TAIL: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_cells[shadow_fill] = key;
          shadow_fill++;
        end
      end
      MODE_REM_HEAD: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value = shadow_cells[0];
          close_gap(0);
        end
      end
      MODE_REM_TAIL: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value = shadow_cells[shadow_fill - 1];
          shadow_fill--;
        end
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          res.found    = 1'b1;
          res.position = 4'(hit);
          close_gap(hit);
        end
      end
      MODE_SEARCH: begin
        if (hit >= 0) begin
          res.found    = 1'b1;
          res.position = 4'(hit);
        end
      end
      default: ;
    endcase
    res.count = 5'(shadow_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("[%0t] result %0d: %s got %h expected %h", $time, checked, field, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_results_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want = apply_list_op(mode_i, value_i);
        if (want.status == STATUS_FULL) full_hits++;
        if (want.status == STATUS_EMPTY) empty_hits++;
        if (want.found) match_hits++;
        expected_results_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("unexpected result, out_value", out_value_i, '0);
        end else begin
          want = expected_results_q.pop_front();
          if (out_value_i !== want.out_value)
            report_mismatch("out_value", out_value_i, want.out_value);
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (position_i !== want.position)
            report_mismatch("position", position_i, want.position);
          if (count_i !== want.count) report_mismatch("count", count_i, want.count);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          checked++;
        end
      end
      pending_o <= expected_results_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the circular list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top import clc_pkg::*;;

  localparam int          CAPACITY      = 16;
  localparam int          TIMEOUT_NS    = 1_000_000;
  localparam int          DRAIN_LIMIT   = 20_000;
  localparam int          SETTLE_CYCLES = 8;
  // Operation codes the package leaves unnamed; the block must treat them as no-ops.
  localparam logic [2:0]  MODE_SPARE_6  = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7  = 3'd7;

  // Flavor of a random burst: grow the list, shrink it, hunt for matches, or pure noise.
  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MATCH,
    BURST_NOISE
  } burst_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [2:0]         mode_i      = '0;
  logic signed [31:0] value_i     = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [31:0] out_value_o;
  logic               found_o;
  logic [3:0]         position_o;
  logic [4:0]         count_o;
  logic [1:0]         status_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int match_hits;
  int send_gap_pct   = 0;
  int stall_pct      = 0;
  int items_sent     = 0;
  int directed_items = 0;

  always #1 clk_i = ~clk_i;

  circular_list_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (32)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  clc_list_checker #(
    .CAPACITY (CAPACITY)
  ) u_list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_i  (out_value_o),
    .found_i      (found_o),
    .position_i   (position_o),
    .count_i      (count_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits),
    .match_hits_o (match_hits)
  );

  // Result-side back-pressure: a fresh coin every cycle, so stalls land on both the
  // accept cycle and the resolve cycle of an item, and on idle cycles too.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one item and hold it until the block takes it. Gaps come before the item,
  // never between presenting it and its acceptance, so valid is only lowered when idling.
  task automatic send_item(input logic [2:0] mode, input logic [31:0] key);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and hold off until the checker has nothing outstanding.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly draw from a small pool (extremes plus a dozen small values) so that
  // duplicates pile up and searches and deletes actually hit; noise bursts and the rest take any 32 bits.
  function automatic logic [31:0] pick_value(input burst_e style);
    if (style == BURST_NOISE || $urandom_range(0, 99) < 20) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [2:0] pick_end_insert();
    return $urandom_range(0, 1) ? MODE_INS_HEAD : MODE_INS_TAIL;
  endfunction

  function automatic logic [2:0] pick_end_remove();
    return $urandom_range(0, 1) ? MODE_REM_HEAD : MODE_REM_TAIL;
  endfunction

  function automatic logic [2:0] pick_lookup();
    return $urandom_range(0, 1) ? MODE_DELETE : MODE_SEARCH;
  endfunction

  // Bias the operation mix by burst flavor so the list swings between full and empty.
  function automatic logic [2:0] pick_mode(input burst_e style);
    int roll;
    roll = $urandom_range(0, 99);
    case (style)
      BURST_FILL:  return (roll < 70) ? pick_end_insert()
                        : (roll < 85) ? pick_lookup() : pick_end_remove();
      BURST_DRAIN: return (roll < 70) ? pick_end_remove()
                        : (roll < 85) ? pick_lookup() : pick_end_insert();
      BURST_MATCH: return (roll < 60) ? pick_lookup()
                        : (roll < 80) ? pick_end_insert() : pick_end_remove();
      default:     return 3'($urandom);
    endcase
  endfunction

  // Directed opening: empty-list corners, spare codes, fill to full with extremes and
  // duplicates, overflow at both ends, then lookups and removals starting from a full list.
  task automatic run_directed();
    int k;
    send_item(MODE_REM_HEAD, 32'h0000_0000);
    send_item(MODE_REM_TAIL, 32'hffff_ffff);
    send_item(MODE_DELETE, 32'h0000_0005);
    send_item(MODE_SEARCH, 32'h0000_0005);
    send_item(MODE_SPARE_6, 32'h7fff_ffff);
    send_item(MODE_SPARE_7, 32'h8000_0000);
    send_item(MODE_INS_TAIL, 32'h8000_0000);
    send_item(MODE_INS_HEAD, 32'h7fff_ffff);
    for (k = 0; k < CAPACITY - 2; k++) send_item(MODE_INS_TAIL, 32'(k % 4));
    send_item(MODE_INS_HEAD, 32'hffff_ffff);
    send_item(MODE_INS_TAIL, 32'hffff_ffff);
    send_item(MODE_SEARCH, 32'h0000_0003);
    send_item(MODE_SEARCH, 32'h8000_0000);
    send_item(MODE_DELETE, 32'h0000_0002);
    send_item(MODE_REM_HEAD, 32'h0000_0000);
    send_item(MODE_REM_TAIL, 32'h0000_0000);
    directed_items = items_sent;
    wait_for_results();
  endtask

  // One idling regime: bursts of random flavor, with an occasional full drain so the
  // block also sees restarts from an idle state mid-phase.
  task automatic run_phase(input int n_items, input int gap_pct, input int stall);
    int     sent;
    int     burst_len;
    int     k;
    int     roll;
    burst_e style;
    sent         = 0;
    send_gap_pct = gap_pct;
    stall_pct   <= stall;
    while (sent < n_items) begin
      roll      = $urandom_range(0, 9);
      style     = (roll < 3) ? BURST_FILL : (roll < 6) ? BURST_DRAIN
                : (roll < 9) ? BURST_MATCH : BURST_NOISE;
      burst_len = $urandom_range(8, 40);
      for (k = 0; k < burst_len && sent < n_items; k++) begin
        send_item(pick_mode(style), pick_value(style));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    // Sender-light / receiver-heavy, then swapped, then flat out.
    run_phase(540, 32, 56);
    run_phase(540, 56, 32);
    run_phase(520, 0, 0);

    // Let every outstanding result drain, bounded, then allow the pipeline to settle.
    in_valid_i <= 1'b0;
    stall_pct  <= 0;
    @(posedge clk_i);
    for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Ran %0d list operations (%0d directed) under three idle/stall mixes; %0d results compared.",
             items_sent, directed_items, checked);
    $display("Full-list inserts: %0d, empty-list removals: %0d, search/delete matches: %0d.",
             full_hits, empty_hits, match_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
